// File: rtl/tism_pkg.sv
// ----------------------------------------------------------------------------
// tism_pkg
// Shared constants and types for the touch identifier slot mapper.
// ----------------------------------------------------------------------------
package tism_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int ID_W       = 32;
  localparam int OUT_IDX_W  = 3;
  localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W      = $clog2(NUM_SLOTS + 1);

  localparam logic [ID_W-1:0] FREE_MARK = {ID_W{1'b1}};

  // request kinds
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_SWEEP  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch request and compare results
    logic execute;   // apply lookup or sweep to slot state
    logic load_out;  // write result register
  } tism_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_sweep;
  } tism_sts_t;

endpackage

// File: rtl/tism_ctrl.sv
// ----------------------------------------------------------------------------
// tism_ctrl
// Sequencer: capture a request, execute it, manage the result register.
// ----------------------------------------------------------------------------
module tism_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  tism_pkg::tism_sts_t sts_i,
  output tism_pkg::tism_cmd_t cmd_o
);

  import tism_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // a lookup waits until the result register can take its answer
        if (sts_i.is_sweep || out_free) begin
          cmd_o.execute  = 1'b1;
          cmd_o.load_out = !sts_i.is_sweep;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/tism_dpath.sv
// ----------------------------------------------------------------------------
// tism_dpath
// Slot table, seen flags, parallel compare and result register.
// ----------------------------------------------------------------------------
module tism_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tism_pkg::tism_cmd_t            cmd_i,
  output tism_pkg::tism_sts_t            sts_o,
  input  logic                           kind_i,
  input  logic [tism_pkg::ID_W-1:0]      finger_id_i,
  output logic                           slot_valid_o,
  output logic [tism_pkg::OUT_IDX_W-1:0] slot_index_o
);

  import tism_pkg::*;

  logic [ID_W-1:0]      slot_ids_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] seen_q, seen_d;
  logic [CNT_W-1:0]     used_q, used_d;

  logic                 kind_q;
  logic [ID_W-1:0]      key_q;
  logic [NUM_SLOTS-1:0] match_q, free1h_q;

  logic [NUM_SLOTS-1:0] used_vec, free_vec, free1h, match_vec;

  logic                  slot_valid_q;
  logic [OUT_IDX_W-1:0]  slot_index_q;

  // compare stage: runs on the incoming request
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      used_vec[i] = (CNT_W'(i) < used_q);
      free_vec[i] = used_vec[i] && (slot_ids_q[i] == FREE_MARK);
    end
    free1h = free_vec & (~free_vec + NUM_SLOTS'(1));  // lowest free slot
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match_vec[i] = used_vec[i] && !free1h[i] && (slot_ids_q[i] == finger_id_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= kind_i;
      key_q    <= finger_id_i;
      match_q  <= match_vec;
      free1h_q <= free1h;
    end
  end

  assign sts_o.is_sweep = (kind_q == KIND_SWEEP);

  // execute stage
  logic                  any_match, have_free, can_append;
  logic [SLOT_IDX_W-1:0] match_idx, free_idx, tgt_idx;
  logic                  wr_en;
  logic                  res_valid;
  logic [SLOT_IDX_W-1:0] res_idx;

  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (match_q[i])  match_idx = SLOT_IDX_W'(i);  // last match wins
      if (free1h_q[i]) free_idx  = SLOT_IDX_W'(i);
    end
    any_match  = |match_q;
    have_free  = |free1h_q;
    can_append = (used_q < CNT_W'(NUM_SLOTS));

    seen_d    = seen_q;
    used_d    = used_q;
    wr_en     = 1'b0;
    tgt_idx   = free_idx;
    res_valid = 1'b0;
    res_idx   = '0;

    if (cmd_i.execute && !sts_o.is_sweep) begin
      if (any_match) begin
        seen_d    = seen_q | match_q;
        res_valid = 1'b1;
        res_idx   = match_idx;
      end else if (have_free) begin
        seen_d    = seen_q | free1h_q;
        wr_en     = 1'b1;
        res_valid = 1'b1;
        res_idx   = free_idx;
      end else if (can_append) begin
        tgt_idx         = used_q[SLOT_IDX_W-1:0];
        seen_d[tgt_idx] = 1'b1;
        used_d          = used_q + CNT_W'(1);
        wr_en           = 1'b1;
        res_valid       = 1'b1;
        res_idx         = tgt_idx;
      end
    end else if (cmd_i.execute) begin
      seen_d = '0;  // flags of unused slots are never set
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      used_q <= '0;
    end else begin
      seen_q <= seen_d;
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (cmd_i.execute && sts_o.is_sweep && used_vec[i] && !seen_q[i]) begin
        slot_ids_q[i] <= FREE_MARK;
      end else if (wr_en && (tgt_idx == SLOT_IDX_W'(i))) begin
        slot_ids_q[i] <= key_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      slot_valid_q <= res_valid;
      slot_index_q <= OUT_IDX_W'(res_idx);
    end
  end

  assign slot_valid_o = slot_valid_q;
  assign slot_index_o = slot_index_q;

endmodule

// File: rtl/touch_id_slot_mapper_core.sv
// ----------------------------------------------------------------------------
// touch_id_slot_mapper_core
// Maps 32-bit touch identifiers onto a small table of slots.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------
//  in      | input     | in_valid_i / in_stall_o   | kind_i, finger_id_i
//  out     | output    | out_valid_o / out_stall_i | slot_valid_o, slot_index_o
//
// For each request, the accept cycle compares the identifier against all
// slots at once; the execute state then applies the lookup or sweep.
// A sweep request produces no result. A lookup waits in its execute cycle
// while an earlier result still sits unclaimed in the output register.
// Reset empties the table (slot count and seen flags cleared); slot contents
// are only read once allocated, so they need no clearing.
//
// Lookup: the last slot whose id matches is the answer; every matching slot
// gets its seen flag set. Otherwise the lowest free slot is reused, else a
// slot is appended; a full table answers slot_valid_o low, index zero.
// Sweep: every slot in use that was not seen since the last sweep is freed.
module touch_id_slot_mapper_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [tism_pkg::ID_W-1:0]      finger_id_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           slot_valid_o,
  output logic [tism_pkg::OUT_IDX_W-1:0] slot_index_o
);

  import tism_pkg::*;

  tism_cmd_t cmd;
  tism_sts_t sts;

  // sequencer
  tism_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // slot table and result register
  tism_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .kind_i       (kind_i),
    .finger_id_i  (finger_id_i),
    .slot_valid_o (slot_valid_o),
    .slot_index_o (slot_index_o)
  );

endmodule

// File: rtl/tism_checker.sv
// ----------------------------------------------------------------------------
// tism_checker
// Port-level checks for the slot mapper, bound to the top level.
// ----------------------------------------------------------------------------
module tism_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           kind_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           slot_valid_o,
  input logic [tism_pkg::OUT_IDX_W-1:0] slot_index_o
);

  import tism_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_valid_o)
      && $stable(slot_index_o))
    else $error("result changed while stalled");

  // a full-table answer carries index zero
  a_invalid_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !slot_valid_o |-> slot_index_o == '0)
    else $error("invalid result with nonzero index");

  // one request at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("request accepted while busy");

  // a sweep never produces a result
  a_sweep_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && kind_i == KIND_SWEEP |-> ##2 !$rose(out_valid_o))
    else $error("sweep produced a result");

endmodule

bind touch_id_slot_mapper_core tism_checker u_tism_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .kind_i       (kind_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .slot_valid_o (slot_valid_o),
  .slot_index_o (slot_index_o)
);

// File: tb/sv/tb_touch_id_slot_mapper_core.sv
// ----------------------------------------------------------------------------
// tb_touch_id_slot_mapper_core
// Self-checking bench for the touch identifier slot mapper. A directed table
// walks the table through fill, reuse, full and sweep corners. Random requests
// drawn from a small identifier pool follow and keep slots matching, freeing
// and filling. Each result is checked against a slot table model or typed answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_touch_id_slot_mapper_core;
  import tism_pkg::*;

  localparam int          RANDOM_REQS   = 2000;
  localparam int          QUIET_TAIL    = 200;      // last requests run without idling
  localparam int          DRAIN_CYCLES  = 20;
  localparam int unsigned CYCLE_LIMIT   = 500_000;
  localparam int          POOL_DEPTH    = 12;
  localparam int          DIRECTED_ROWS = 22;

  // one result as the block reports it
  typedef struct packed {
    logic                 slot_valid;
    logic [OUT_IDX_W-1:0] slot_index;
  } slot_result_t;

  // directed row: the answer is typed in only when fixed is set
  typedef struct packed {
    logic                 kind;
    logic [ID_W-1:0]      finger_id;
    logic                 fixed;
    logic                 want_valid;
    logic [OUT_IDX_W-1:0] want_index;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 kind_i;
  logic [ID_W-1:0]      finger_id_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 slot_valid_o;
  logic [OUT_IDX_W-1:0] slot_index_o;

  // model of the slot table
  logic [ID_W-1:0] table_ids  [NUM_SLOTS];
  logic            table_seen [NUM_SLOTS];
  int unsigned     table_used;

  slot_result_t pending_slots [$];   // answers still owed by the block
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  bit           idle_on     = 1'b1;  // random gaps and stalls allowed

  // Directed walk. Notes per row give the table state it aims at.
  stim_row_t directed [DIRECTED_ROWS] = '{
    '{KIND_SWEEP,  32'h0000_0000, 1'b0, 1'b0, 3'd0},  // sweep on empty table
    '{KIND_LOOKUP, 32'h0000_0000, 1'b1, 1'b1, 3'd0},  // first lookup lands in slot 0
    '{KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0},  // marker key appended
    '{KIND_LOOKUP, 32'h0000_0000, 1'b1, 1'b1, 3'd0},  // hit slot 0
    '{KIND_LOOKUP, 32'h1234_5678, 1'b0, 1'b0, 3'd0},  // reuses the marker slot
    '{KIND_SWEEP,  32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0},  // all seen: nothing freed
    '{KIND_LOOKUP, 32'h1234_5678, 1'b0, 1'b0, 3'd0},
    '{KIND_SWEEP,  32'h0000_0000, 1'b0, 1'b0, 3'd0},  // frees slot 0
    '{KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0},  // marker key, one free slot
    '{KIND_LOOKUP, 32'hA5A5_A5A5, 1'b0, 1'b0, 3'd0},
    '{KIND_LOOKUP, 32'h5A5A_5A5A, 1'b0, 1'b0, 3'd0},  // appends up to a full table
    '{KIND_LOOKUP, 32'h8000_0000, 1'b0, 1'b0, 3'd0},
    '{KIND_LOOKUP, 32'h0000_0001, 1'b0, 1'b0, 3'd0},
    '{KIND_LOOKUP, 32'h7FFF_FFFF, 1'b0, 1'b0, 3'd0},
    '{KIND_LOOKUP, 32'hDEAD_BEEF, 1'b0, 1'b0, 3'd0},
    '{KIND_LOOKUP, 32'hCAFE_F00D, 1'b0, 1'b0, 3'd0},
    '{KIND_LOOKUP, 32'h0BAD_F00D, 1'b1, 1'b0, 3'd0},  // table full
    '{KIND_SWEEP,  32'h5555_5555, 1'b0, 1'b0, 3'd0},  // frees unseen slot 1
    '{KIND_SWEEP,  32'hAAAA_AAAA, 1'b0, 1'b0, 3'd0},  // frees everything
    '{KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0},  // marker key over all-free table
    '{KIND_SWEEP,  32'h0000_0000, 1'b0, 1'b0, 3'd0},
    '{KIND_LOOKUP, 32'h0000_0000, 1'b0, 1'b0, 3'd0}
  };

  touch_id_slot_mapper_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .finger_id_i  (finger_id_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .slot_valid_o (slot_valid_o),
    .slot_index_o (slot_index_o)
  );

  always #5 clk_i = ~clk_i;

  // Lookup: the first free slot is only a candidate, never a hit; the last
  // hit wins and every hit gets its seen flag. Then free reuse, then append.
  function automatic slot_result_t map_finger(input logic [ID_W-1:0] key);
    slot_result_t res;
    bit           hit;
    bit           have_free;
    int unsigned  hit_at;
    int unsigned  free_at;
    int unsigned  i;
    res       = '0;
    hit       = 1'b0;
    have_free = 1'b0;
    hit_at    = 0;
    free_at   = 0;
    for (i = 0; i < table_used; i++) begin
      if (table_ids[i] == FREE_MARK && !have_free) begin
        have_free = 1'b1;
        free_at   = i;
      end else if (table_ids[i] == key) begin
        hit           = 1'b1;
        hit_at        = i;
        table_seen[i] = 1'b1;
      end
    end
    if (hit) begin
      res.slot_valid = 1'b1;
      res.slot_index = OUT_IDX_W'(hit_at);
    end else if (have_free) begin
      table_ids[free_at]  = key;
      table_seen[free_at] = 1'b1;
      res.slot_valid      = 1'b1;
      res.slot_index      = OUT_IDX_W'(free_at);
    end else if (table_used < NUM_SLOTS) begin
      table_ids[table_used]  = key;
      table_seen[table_used] = 1'b1;
      res.slot_valid         = 1'b1;
      res.slot_index         = OUT_IDX_W'(table_used);
      table_used++;
    end
    return res;
  endfunction

  // Sweep: unseen slots in use go back to the marker, seen flags clear.
  function automatic void sweep_table();
    int unsigned i;
    for (i = 0; i < table_used; i++) begin
      if (!table_seen[i]) table_ids[i] = FREE_MARK;
      table_seen[i] = 1'b0;
    end
  endfunction

  function automatic void flag_error(input string what);
    error_count++;
    if (error_count <= 10) $display("%s", what);
  endfunction

  // Drive one request and hold it until accepted. Valid is only dropped for
  // a gap, so back-to-back requests never lower and raise it in one step.
  task automatic issue_request(input logic kind, input logic [ID_W-1:0] id,
                               input bit fixed, input slot_result_t want);
    slot_result_t res;
    int unsigned  gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    finger_id_i <= id;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // accepted at this edge
    if (kind == KIND_SWEEP) begin
      sweep_table();
    end else begin
      res = map_finger(id);
      if (fixed) res = want;
      pending_slots.push_back(res);
    end
  endtask

  // Output side stalls in random bursts while idling is allowed.
  initial begin : out_stall_gen
    int unsigned burst;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 16);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result check against the oldest owed answer.
  always @(posedge clk_i) begin : result_check
    slot_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_slots.size() == 0) begin
        flag_error($sformatf("unexpected result: valid=%0b index=%0d",
                             slot_valid_o, slot_index_o));
      end else begin
        want = pending_slots.pop_front();
        if (slot_valid_o !== want.slot_valid || slot_index_o !== want.slot_index)
          flag_error($sformatf("slot mismatch: want valid=%0b index=%0d, got valid=%0b index=%0d",
                               want.slot_valid, want.slot_index,
                               slot_valid_o, slot_index_o));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** touch_id_slot_mapper_core: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ID_W-1:0] id_pool [POOL_DEPTH];
    logic [ID_W-1:0] key;
    logic            kind;
    int unsigned     pool_n;
    int unsigned     pick;
    int unsigned     n;
    int unsigned     i;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = KIND_LOOKUP;
    finger_id_i = '0;
    table_used  = 0;
    for (i = 0; i < NUM_SLOTS; i++) table_seen[i] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIRECTED_ROWS; i++)
      issue_request(directed[i].kind, directed[i].finger_id, directed[i].fixed,
                    '{directed[i].want_valid, directed[i].want_index});

    // Random part: mostly lookups from a small pool so ids recur, get seen,
    // survive sweeps and overflow the table; markers and fresh ids as noise.
    for (i = 0; i < POOL_DEPTH; i++) id_pool[i] = $urandom();
    id_pool[0] = '0;
    id_pool[1] = FREE_MARK - 1;
    pool_n     = POOL_DEPTH;
    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n % 100 == 0) begin
        idle_on = (n < RANDOM_REQS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
        pool_n  = $urandom_range(4, POOL_DEPTH);
        id_pool[$urandom_range(0, POOL_DEPTH - 1)] = $urandom();
      end
      pick = $urandom_range(0, 99);
      kind = KIND_LOOKUP;
      if (pick < 12) begin
        kind = KIND_SWEEP;
        key  = $urandom();
      end else if (pick < 17) begin
        key = FREE_MARK;
      end else if (pick < 25) begin
        key = $urandom();
      end else begin
        key = id_pool[$urandom_range(0, pool_n - 1)];
      end
      issue_request(kind, key, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_slots.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_slots.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_slots.size()));

    if (error_count == 0) begin
      $display("** touch_id_slot_mapper_core: PASSED **");
    end else begin
      $display("** touch_id_slot_mapper_core: FAILED **");
    end
    $finish;
  end

endmodule
